/* sv/tclut_pkg.sv */
package tclut_pkg;

    // Sizes fixed by the field definitions.
    localparam int CODE_W  = 16;
    localparam int CHAN_W  = 16;
    localparam int INDEX_W = 13;
    localparam int GRID_W  = 5;
    localparam int ENTRY_W = 3 * CHAN_W;

    // Default cube size and grid register reset value.
    localparam int              MAX_GRID_DEF = 17;
    localparam logic [GRID_W-1:0] GRID_RESET = 5'd17;

    // One full unit in u0.16 and u16 coding, twice that unit, and the full fraction.
    localparam logic [16:0] UNIT      = 17'd65535;
    localparam logic [16:0] TWO_UNIT  = 17'd131070;
    localparam logic [15:0] FRAC_ONE  = 16'hFFFF;

    // Request function codes.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    // Stage enables handed to the per-axis locate pipeline.
    typedef struct packed {
        logic pos;
        logic split;
    } loc_en_t;

    // Stage enables handed to the per-channel blend pipeline.
    typedef struct packed {
        logic diff;
        logic prod;
        logic sum;
        logic quo;
    } blend_en_t;

endpackage

/* sv/tclut_ram.sv */
module tclut_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4913,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_a_reg <= mem[raddr_a];
            rd_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

/* sv/tclut_locate.sv */
module tclut_locate #(
    parameter int GW = 5
) (
    input  logic                    clk,
    input  tclut_pkg::loc_en_t      en,
    input  logic [15:0]             code,
    input  logic [GW-1:0]           gm1,
    input  logic [GW-1:0]           gm2,
    output logic [GW-1:0]           lat,
    output logic [15:0]             frac
);

    import tclut_pkg::*;

    localparam int PW = 16 + GW;

    logic [PW-1:0] pos_reg;
    logic [GW-1:0] cell_reg;
    logic [15:0]   frac_reg;

    logic [GW-1:0] q0;
    logic [16:0]   rem;
    logic [GW-1:0] cell_raw;
    logic [16:0]   rem_fix;
    logic [GW-1:0] cell_next;
    logic [15:0]   frac_next;

    // Division by 65535: pos = hi*65536 + lo = hi*65535 + (hi + lo), and
    // hi + lo stays below twice 65535, so one compare and subtract fixes it.
    always_comb
    begin
        q0  = pos_reg[PW-1:16];
        rem = {1'b0, pos_reg[15:0]} + 17'(q0);
        if (rem >= UNIT)
        begin
            cell_raw = q0 + GW'(1);
            rem_fix  = rem - UNIT;
        end
        else
        begin
            cell_raw = q0;
            rem_fix  = rem;
        end
        // A full-scale code lands on the last lattice point; it is taken
        // as the far corner of the last cell.
        if (cell_raw >= gm1)
        begin
            cell_next = gm2;
            frac_next = FRAC_ONE;
        end
        else
        begin
            cell_next = cell_raw;
            frac_next = rem_fix[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.pos)
        begin
            pos_reg <= PW'(code) * PW'(gm1);
        end
        if (en.split)
        begin
            cell_reg <= cell_next;
            frac_reg <= frac_next;
        end
    end

    assign lat  = cell_reg;
    assign frac = frac_reg;

endmodule

/* sv/tclut_blend.sv */
module tclut_blend (
    input  logic                  clk,
    input  tclut_pkg::blend_en_t  en,
    input  logic [15:0]           c0,
    input  logic [15:0]           v1,
    input  logic [15:0]           v2,
    input  logic [15:0]           c7,
    input  logic [15:0]           w1,
    input  logic [15:0]           w2,
    input  logic [15:0]           w3,
    output logic [15:0]           q
);

    import tclut_pkg::*;

    logic signed [16:0] d1_reg;
    logic signed [16:0] d2_reg;
    logic signed [16:0] d3_reg;
    logic [15:0]        c0_d_reg;
    logic [15:0]        w1_reg;
    logic [15:0]        w2_reg;
    logic [15:0]        w3_reg;

    logic signed [33:0] p1_reg;
    logic signed [33:0] p2_reg;
    logic signed [33:0] p3_reg;
    logic [15:0]        c0_p_reg;

    logic [31:0]        t_reg;
    logic [15:0]        q_reg;

    logic signed [35:0] acc;
    logic [31:0]        t_next;
    logic [16:0]        x;
    logic [16:0]        q_wide;
    logic [15:0]        q_next;

    // Sum of the corner term and the three weighted edge steps, with the
    // rounding offset already added.
    always_comb
    begin
        acc = $signed({4'd0, c0_p_reg, 16'h0}) - $signed({20'd0, c0_p_reg})
            + 36'(p1_reg) + 36'(p2_reg) + 36'(p3_reg) + 36'sd32767;
        if (acc < 36'sd0)
        begin
            t_next = 32'd0;
        end
        else
        begin
            t_next = acc[31:0];
        end
    end

    // t / 65535 = hi + (hi + lo) / 65535, and hi + lo is at most twice 65535.
    always_comb
    begin
        x = 17'(t_reg[31:16]) + 17'(t_reg[15:0]);
        if (x >= TWO_UNIT)
        begin
            q_wide = 17'(t_reg[31:16]) + 17'd2;
        end
        else if (x >= UNIT)
        begin
            q_wide = 17'(t_reg[31:16]) + 17'd1;
        end
        else
        begin
            q_wide = 17'(t_reg[31:16]);
        end
        if (q_wide > {1'b0, FRAC_ONE})
        begin
            q_next = FRAC_ONE;
        end
        else
        begin
            q_next = q_wide[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.diff)
        begin
            d1_reg   <= $signed({1'b0, v1}) - $signed({1'b0, c0});
            d2_reg   <= $signed({1'b0, v2}) - $signed({1'b0, v1});
            d3_reg   <= $signed({1'b0, c7}) - $signed({1'b0, v2});
            c0_d_reg <= c0;
            w1_reg   <= w1;
            w2_reg   <= w2;
            w3_reg   <= w3;
        end
        if (en.prod)
        begin
            p1_reg   <= d1_reg * $signed({1'b0, w1_reg});
            p2_reg   <= d2_reg * $signed({1'b0, w2_reg});
            p3_reg   <= d3_reg * $signed({1'b0, w3_reg});
            c0_p_reg <= c0_d_reg;
        end
        if (en.sum)
        begin
            t_reg <= t_next;
        end
        if (en.quo)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

/* sv/tetrahedral_clut_interpolation.sv */
// Tetrahedral interpolation through a three-channel 3D color lookup cube.
//
// Requests arrive on the in_valid/in_ready channel. A load request (func
// low) writes entry_c0..entry_c2 into the cube entry at entry_index and
// gives no result; an index beyond the cube is dropped. An evaluate request
// (func high) looks up sample_r/g/b and gives one result on the
// out_valid/out_ready channel. Entries must be loaded before they are used.
// The grid size register is written through cfg_we/cfg_wdata while idle.
//
// Throughput is one request per clock while out_ready keeps results
// moving: the datapath is a ten-stage pipeline with a valid bit per stage
// and reads four cube corners per cycle from two dual-read copies of the
// cube memory. An evaluate gives its result on out_c0..out_c2 from the
// last stage. When the receiver holds out_ready low the result holds, the
// stages behind it fill up one by one, and in_ready drops only once every
// stage is full. Reset clears the stage valid bits and sets the grid to 17;
// the cube contents are left as they are, and no clearing pass is run.
module tetrahedral_clut_interpolation #(
    parameter int MAX_GRID = tclut_pkg::MAX_GRID_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tclut_pkg::GRID_W-1:0]  cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [tclut_pkg::INDEX_W-1:0] entry_index,
    input  logic [15:0]                   entry_c0,
    input  logic [15:0]                   entry_c1,
    input  logic [15:0]                   entry_c2,
    input  logic [15:0]                   sample_r,
    input  logic [15:0]                   sample_g,
    input  logic [15:0]                   sample_b,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [15:0]                   out_c0,
    output logic [15:0]                   out_c1,
    output logic [15:0]                   out_c2
);

    import tclut_pkg::*;

    localparam int DEPTH  = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int AW     = $clog2(DEPTH);
    localparam int GW     = $clog2(MAX_GRID + 1);
    localparam int STAGES = 10;

    // Grid register and the strides derived from it.
    logic [GRID_W-1:0] grid_reg;
    logic [GW-1:0]     g_use;
    logic [GW-1:0]     gm1;
    logic [GW-1:0]     gm2;
    logic [AW-1:0]     gsq_reg;
    logic [AW-1:0]     s3_reg;

    // Pipeline control. Stage k loads when en[k] is high.
    logic [STAGES:1]   vld_reg;
    logic [STAGES:1]   vld_next;
    logic [STAGES:1]   en;

    // Stage 1: captured request.
    logic              func1_reg;
    logic [INDEX_W-1:0] idx1_reg;
    logic [ENTRY_W-1:0] ent1_reg;
    logic [15:0]       sr1_reg;
    logic [15:0]       sg1_reg;
    logic [15:0]       sb1_reg;

    // Stages 2 to 5 carry the load payload alongside the evaluate math.
    logic              func2_reg;
    logic              func3_reg;
    logic              func4_reg;
    logic              func5_reg;
    logic [INDEX_W-1:0] idx2_reg;
    logic [INDEX_W-1:0] idx3_reg;
    logic [INDEX_W-1:0] idx4_reg;
    logic [INDEX_W-1:0] idx5_reg;
    logic [ENTRY_W-1:0] ent2_reg;
    logic [ENTRY_W-1:0] ent3_reg;
    logic [ENTRY_W-1:0] ent4_reg;
    logic [ENTRY_W-1:0] ent5_reg;

    // Stage 3 outputs of the locate pipelines.
    logic [GW-1:0]     cell_r;
    logic [GW-1:0]     cell_g;
    logic [GW-1:0]     cell_b;
    logic [15:0]       frac_r;
    logic [15:0]       frac_g;
    logic [15:0]       frac_b;

    // Stage 4: cell base address, tetrahedron offsets and weights.
    logic [AW-1:0]     base4_reg;
    logic [AW-1:0]     s1_4_reg;
    logic [AW-1:0]     s2_4_reg;
    logic [15:0]       w1_4_reg;
    logic [15:0]       w2_4_reg;
    logic [15:0]       w3_4_reg;
    logic [AW-1:0]     base_next;
    logic [AW-1:0]     s1_next;
    logic [AW-1:0]     s2_next;
    logic [15:0]       w1_next;
    logic [15:0]       w2_next;
    logic [15:0]       w3_next;
    logic [AW-1:0]     st_r;
    logic [AW-1:0]     st_g;
    logic [AW-1:0]     st_b;

    // Stage 5: the four corner addresses.
    logic [AW-1:0]     addr5_reg [4];
    logic [15:0]       w1_5_reg;
    logic [15:0]       w2_5_reg;
    logic [15:0]       w3_5_reg;

    // Stage 6: corner data sits in the memory read registers.
    logic [15:0]       w1_6_reg;
    logic [15:0]       w2_6_reg;
    logic [15:0]       w3_6_reg;
    logic [ENTRY_W-1:0] rd_c0;
    logic [ENTRY_W-1:0] rd_v1;
    logic [ENTRY_W-1:0] rd_v2;
    logic [ENTRY_W-1:0] rd_c7;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    loc_en_t           loc_en;
    blend_en_t         bl_en;

    // Grid sizes outside 2..MAX_GRID are pulled to the nearest legal size.
    always_comb
    begin
        if (grid_reg < GRID_W'(2))
        begin
            g_use = GW'(2);
        end
        else if (int'(grid_reg) > MAX_GRID)
        begin
            g_use = GW'(MAX_GRID);
        end
        else
        begin
            g_use = GW'(grid_reg);
        end
        gm1 = g_use - GW'(1);
        gm2 = g_use - GW'(2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg <= GRID_RESET;
        end
        else if (cfg_we)
        begin
            grid_reg <= cfg_wdata;
        end
    end

    // The plane stride is registered; a request reaches stage 4 well after
    // a grid write has settled here.
    always_ff @(posedge clk)
    begin
        gsq_reg <= AW'(AW'(g_use) * AW'(g_use));
        s3_reg  <= AW'(1) + AW'(g_use) + AW'(AW'(g_use) * AW'(g_use));
    end

    // A stage may load when it is empty or when the stage after it moves.
    always_comb
    begin
        en[STAGES] = !vld_reg[STAGES] || out_ready;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    // Load requests leave the pipeline once they have written the memory.
    always_comb
    begin
        vld_next[1] = in_valid;
        for (int k = 2; k <= STAGES; k++)
        begin
            vld_next[k] = vld_reg[k-1];
        end
        vld_next[6] = vld_reg[5] && (func5_reg == FUNC_EVAL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign in_ready  = en[1];
    assign out_valid = vld_reg[STAGES];

    // Stages 1 to 3: request capture and payload carry.
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            func1_reg <= func;
            idx1_reg  <= entry_index;
            ent1_reg  <= {entry_c2, entry_c1, entry_c0};
            sr1_reg   <= sample_r;
            sg1_reg   <= sample_g;
            sb1_reg   <= sample_b;
        end
        if (en[2])
        begin
            func2_reg <= func1_reg;
            idx2_reg  <= idx1_reg;
            ent2_reg  <= ent1_reg;
        end
        if (en[3])
        begin
            func3_reg <= func2_reg;
            idx3_reg  <= idx2_reg;
            ent3_reg  <= ent2_reg;
        end
    end

    assign loc_en.pos   = en[2];
    assign loc_en.split = en[3];

    tclut_locate #(
        .GW (GW)
    ) u_loc_r (
        .clk  (clk),
        .en   (loc_en),
        .code (sr1_reg),
        .gm1  (gm1),
        .gm2  (gm2),
        .lat  (cell_r),
        .frac (frac_r)
    );

    tclut_locate #(
        .GW (GW)
    ) u_loc_g (
        .clk  (clk),
        .en   (loc_en),
        .code (sg1_reg),
        .gm1  (gm1),
        .gm2  (gm2),
        .lat  (cell_g),
        .frac (frac_g)
    );

    tclut_locate #(
        .GW (GW)
    ) u_loc_b (
        .clk  (clk),
        .en   (loc_en),
        .code (sb1_reg),
        .gm1  (gm1),
        .gm2  (gm2),
        .lat  (cell_b),
        .frac (frac_b)
    );

    // Stage 4: the order of the three fractions picks the tetrahedron. Ties
    // go to the first matching ordering in the list below. The two inner
    // corners are reached by stepping along the largest fraction first.
    always_comb
    begin
        st_r = AW'(1);
        st_g = AW'(g_use);
        st_b = gsq_reg;
        base_next = AW'(AW'(cell_b) * gsq_reg) + AW'(AW'(cell_g) * AW'(g_use))
                  + AW'(cell_r);
        if (frac_r >= frac_g && frac_g >= frac_b)
        begin
            s1_next = st_r;
            s2_next = st_r + st_g;
            w1_next = frac_r;
            w2_next = frac_g;
            w3_next = frac_b;
        end
        else if (frac_r >= frac_b && frac_b >= frac_g)
        begin
            s1_next = st_r;
            s2_next = st_r + st_b;
            w1_next = frac_r;
            w2_next = frac_b;
            w3_next = frac_g;
        end
        else if (frac_b >= frac_r && frac_r >= frac_g)
        begin
            s1_next = st_b;
            s2_next = st_b + st_r;
            w1_next = frac_b;
            w2_next = frac_r;
            w3_next = frac_g;
        end
        else if (frac_g >= frac_r && frac_r >= frac_b)
        begin
            s1_next = st_g;
            s2_next = st_g + st_r;
            w1_next = frac_g;
            w2_next = frac_r;
            w3_next = frac_b;
        end
        else if (frac_g >= frac_b && frac_b >= frac_r)
        begin
            s1_next = st_g;
            s2_next = st_g + st_b;
            w1_next = frac_g;
            w2_next = frac_b;
            w3_next = frac_r;
        end
        else
        begin
            s1_next = st_b;
            s2_next = st_b + st_g;
            w1_next = frac_b;
            w2_next = frac_g;
            w3_next = frac_r;
        end
    end

    // Stages 4 to 6.
    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            func4_reg <= func3_reg;
            idx4_reg  <= idx3_reg;
            ent4_reg  <= ent3_reg;
            base4_reg <= base_next;
            s1_4_reg  <= s1_next;
            s2_4_reg  <= s2_next;
            w1_4_reg  <= w1_next;
            w2_4_reg  <= w2_next;
            w3_4_reg  <= w3_next;
        end
        if (en[5])
        begin
            func5_reg    <= func4_reg;
            idx5_reg     <= idx4_reg;
            ent5_reg     <= ent4_reg;
            addr5_reg[0] <= base4_reg;
            addr5_reg[1] <= base4_reg + s1_4_reg;
            addr5_reg[2] <= base4_reg + s2_4_reg;
            addr5_reg[3] <= base4_reg + s3_reg;
            w1_5_reg     <= w1_4_reg;
            w2_5_reg     <= w2_4_reg;
            w3_5_reg     <= w3_4_reg;
        end
        if (en[6])
        begin
            w1_6_reg <= w1_5_reg;
            w2_6_reg <= w2_5_reg;
            w3_6_reg <= w3_5_reg;
        end
    end

    // Loads write and evaluates read on the same stage move, so every
    // evaluate sees exactly the loads that were accepted ahead of it.
    assign wr_en   = en[6] && vld_reg[5] && (func5_reg == FUNC_LOAD)
                     && (int'(idx5_reg) < DEPTH);
    assign wr_addr = AW'(idx5_reg);

    tclut_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram_lo (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (ent5_reg),
        .re      (en[6]),
        .raddr_a (addr5_reg[0]),
        .raddr_b (addr5_reg[1]),
        .rdata_a (rd_c0),
        .rdata_b (rd_v1)
    );

    tclut_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram_hi (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (ent5_reg),
        .re      (en[6]),
        .raddr_a (addr5_reg[2]),
        .raddr_b (addr5_reg[3]),
        .rdata_a (rd_v2),
        .rdata_b (rd_c7)
    );

    // Stages 7 to 10: one blend pipeline per output channel.
    assign bl_en.diff = en[7];
    assign bl_en.prod = en[8];
    assign bl_en.sum  = en[9];
    assign bl_en.quo  = en[10];

    tclut_blend u_blend_c0 (
        .clk (clk),
        .en  (bl_en),
        .c0  (rd_c0[15:0]),
        .v1  (rd_v1[15:0]),
        .v2  (rd_v2[15:0]),
        .c7  (rd_c7[15:0]),
        .w1  (w1_6_reg),
        .w2  (w2_6_reg),
        .w3  (w3_6_reg),
        .q   (out_c0)
    );

    tclut_blend u_blend_c1 (
        .clk (clk),
        .en  (bl_en),
        .c0  (rd_c0[31:16]),
        .v1  (rd_v1[31:16]),
        .v2  (rd_v2[31:16]),
        .c7  (rd_c7[31:16]),
        .w1  (w1_6_reg),
        .w2  (w2_6_reg),
        .w3  (w3_6_reg),
        .q   (out_c1)
    );

    tclut_blend u_blend_c2 (
        .clk (clk),
        .en  (bl_en),
        .c0  (rd_c0[47:32]),
        .v1  (rd_v1[47:32]),
        .v2  (rd_v2[47:32]),
        .c7  (rd_c7[47:32]),
        .w1  (w1_6_reg),
        .w2  (w2_6_reg),
        .w3  (w3_6_reg),
        .q   (out_c2)
    );

endmodule

/* sv/tclut_checker.sv */
module tclut_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_c0,
    input logic [15:0] out_c1,
    input logic [15:0] out_c2
);

    // A result that is not taken holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_c0)
            && $stable(out_c1) && $stable(out_c2))
        else $error("result changed or vanished while stalled");

    // Reset empties the pipeline.
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result shown right after reset");

    // With the output stage free or draining, every stage can move.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("request refused while the output stage can move");

    // A request refused now stays pending: refusal only happens with a
    // full, stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> out_valid && !out_ready)
        else $error("request refused without a stalled result");

endmodule

bind tetrahedral_clut_interpolation tclut_checker u_tclut_checker (.*);

/* bench/tb_tetrahedral_clut_interpolation.sv */
`timescale 1ns / 1ps

// Self-checking bench for the tetrahedral color cube interpolator.
// Requests are queued by the stimulus thread, presented by a bursty driver,
// predicted at the moment they are accepted, and the results are checked in
// order by a monitor whose ready line follows its own stall pattern.
module tb_tetrahedral_clut_interpolation;

    import tclut_pkg::*;

    // The cube in the bench is sized for the default build of the block.
    localparam int GRID_MAX     = MAX_GRID_DEF;
    localparam int CUBE_N       = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_HOLD    = 150;
    localparam int LIMIT_CYCLES = 500000;

    // One request as the driver presents it.
    typedef struct {
        logic               func;
        logic [INDEX_W-1:0] index;
        logic [15:0]        c0;
        logic [15:0]        c1;
        logic [15:0]        c2;
        logic [15:0]        r;
        logic [15:0]        g;
        logic [15:0]        b;
    } clut_req_t;

    // One interpolated color as the block returns it.
    typedef struct {
        logic [15:0] c0;
        logic [15:0] c1;
        logic [15:0] c2;
    } rgb_t;

    // Patterns that the receiver cycles through between its stretches.
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic              clk;
    logic              rst_n       = 1'b0;
    logic              cfg_we      = 1'b0;
    logic [GRID_W-1:0] cfg_wdata   = '0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic              func        = FUNC_LOAD;
    logic [INDEX_W-1:0] entry_index = '0;
    logic [15:0]       entry_c0    = '0;
    logic [15:0]       entry_c1    = '0;
    logic [15:0]       entry_c2    = '0;
    logic [15:0]       sample_r    = '0;
    logic [15:0]       sample_g    = '0;
    logic [15:0]       sample_b    = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic [15:0]       out_c0;
    logic [15:0]       out_c1;
    logic [15:0]       out_c2;

    tetrahedral_clut_interpolation u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .entry_index (entry_index),
        .entry_c0    (entry_c0),
        .entry_c1    (entry_c1),
        .entry_c2    (entry_c2),
        .sample_r    (sample_r),
        .sample_g    (sample_g),
        .sample_b    (sample_b),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_c0      (out_c0),
        .out_c1      (out_c1),
        .out_c2      (out_c2)
    );

    // Shadow copy of the cube and of the grid register, kept in step with
    // the block by applying every accepted request in acceptance order.
    logic [15:0]       cube_shadow [CUBE_N][3];
    logic [GRID_W-1:0] grid_shadow = GRID_RESET;

    clut_req_t req_q [$];
    rgb_t      rgb_expected_q [$];

    // Flow control knobs that the stimulus thread flips at the falling edge.
    bit sender_gaps    = 1'b1;
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;

    int fail_cnt     = 0;
    int load_cnt     = 0;
    int eval_cnt     = 0;
    int result_cnt   = 0;
    int backpressure = 0;
    int phase_cnt    = 0;
    int cycle_cnt    = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Splits one u0.16 coordinate into the lattice cell and the fraction
    // inside it, in units of 1/65535. The top code lands in the last cell
    // with a full fraction rather than one cell beyond the cube.
    function automatic void split_code(input logic [15:0] code, input int unsigned gp,
                                       output int unsigned lat, output longint frac);
        int unsigned pos;
        pos = code * (gp - 1);
        lat = pos / 65535;
        if (lat >= gp - 1)
            lat = gp - 2;
        frac = longint'(pos - lat * 65535);
    endfunction

    // Tetrahedral interpolation of one sample against the shadow cube.
    function automatic rgb_t blend_sample(input clut_req_t rq);
        int unsigned gp;
        int unsigned cr;
        int unsigned cg;
        int unsigned cb;
        int unsigned base;
        int unsigned s1;
        int unsigned s2;
        int unsigned far_corner;
        longint      dr;
        longint      dg;
        longint      db;
        longint      w1;
        longint      w2;
        longint      w3;
        longint      c000;
        longint      v1;
        longint      v2;
        longint      c111;
        longint      acc;
        longint      q;
        logic [15:0] chan [3];
        rgb_t        res;

        // Register values outside 2..GRID_MAX are pulled back into range.
        gp = grid_shadow;
        if (gp < 2)
            gp = 2;
        if (gp > GRID_MAX)
            gp = GRID_MAX;

        split_code(rq.r, gp, cr, dr);
        split_code(rq.g, gp, cg, dg);
        split_code(rq.b, gp, cb, db);
        base       = cb * gp * gp + cg * gp + cr;
        far_corner = base + 1 + gp + gp * gp;

        // The fractions are ordered to pick one of the six tetrahedra; on
        // ties the earlier ordering wins.
        if (dr >= dg && dg >= db)
        begin
            s1 = 1;       s2 = 1 + gp;       w1 = dr; w2 = dg; w3 = db;
        end
        else if (dr >= db && db >= dg)
        begin
            s1 = 1;       s2 = 1 + gp * gp;  w1 = dr; w2 = db; w3 = dg;
        end
        else if (db >= dr && dr >= dg)
        begin
            s1 = gp * gp; s2 = gp * gp + 1;  w1 = db; w2 = dr; w3 = dg;
        end
        else if (dg >= dr && dr >= db)
        begin
            s1 = gp;      s2 = gp + 1;       w1 = dg; w2 = dr; w3 = db;
        end
        else if (dg >= db && db >= dr)
        begin
            s1 = gp;      s2 = gp + gp * gp; w1 = dg; w2 = db; w3 = dr;
        end
        else
        begin
            s1 = gp * gp; s2 = gp * gp + gp; w1 = db; w2 = dg; w3 = dr;
        end

        for (int ch = 0; ch < 3; ch++)
        begin
            c000 = cube_shadow[base][ch];
            v1   = cube_shadow[base + s1][ch];
            v2   = cube_shadow[base + s2][ch];
            c111 = cube_shadow[far_corner][ch];
            acc  = c000 * 65535 + w1 * (v1 - c000) + w2 * (v2 - v1) + w3 * (c111 - v2);
            if (acc < 0)
                acc = 0;
            // 65535 is odd, so adding half a unit rounds to nearest with no ties.
            q = (acc + 32767) / 65535;
            if (q > 65535)
                q = 65535;
            chan[ch] = q[15:0];
        end
        res.c0 = chan[0];
        res.c1 = chan[1];
        res.c2 = chan[2];
        return res;
    endfunction

    // Applies one accepted request: a load updates the shadow cube (indexes
    // past the physical cube are dropped), an evaluate queues its color.
    task automatic apply_request(input clut_req_t rq);
        if (rq.func == FUNC_LOAD)
        begin
            load_cnt++;
            if (rq.index < CUBE_N)
            begin
                cube_shadow[rq.index][0] = rq.c0;
                cube_shadow[rq.index][1] = rq.c1;
                cube_shadow[rq.index][2] = rq.c2;
            end
        end
        else
        begin
            eval_cnt++;
            rgb_expected_q.push_back(blend_sample(rq));
        end
    endtask

    // Driver. It works in bursts with idle gaps between them, and holds a
    // request steady until the block takes it.
    int        burst_left = 0;
    int        idle_left  = 0;
    clut_req_t req_now;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                apply_request(req_now);
            if (in_valid && !in_ready)
                backpressure++;

            if (!in_valid || in_ready)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    in_valid <= 1'b0;
                end
                else if (req_q.size() > 0)
                begin
                    req_now = req_q.pop_front();
                    in_valid    <= 1'b1;
                    func        <= req_now.func;
                    entry_index <= req_now.index;
                    entry_c0    <= req_now.c0;
                    entry_c1    <= req_now.c1;
                    entry_c2    <= req_now.c2;
                    sample_r    <= req_now.r;
                    sample_g    <= req_now.g;
                    sample_b    <= req_now.b;
                    if (burst_left > 0)
                        burst_left--;
                    else if (sender_gaps)
                    begin
                        // Some bursts run with no gap after them at all.
                        burst_left = $urandom_range(0, 24);
                        idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready pattern. It switches between fully open, coin flip,
    // mostly stalled and periodic stretches, and once on request it holds
    // off long enough to back the whole pipeline up into the input.
    rx_mode_t rx_mode   = RX_OPEN;
    int       rx_left   = 0;
    int       rx_tick   = 0;
    int       hold_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_tick++;
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 80);
            end
            else
            begin
                rx_left--;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_COIN:   out_ready <= $urandom_range(0, 1);
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= (rx_tick % 3 != 0);
                endcase
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // Monitor. Every accepted color is compared with the oldest prediction.
    always @(posedge clk)
    begin
        rgb_t want;
        if (rst_n && out_valid && out_ready)
        begin
            result_cnt++;
            if (rgb_expected_q.size() == 0)
            begin
                $error("result with no request waiting: c0 %0d c1 %0d c2 %0d",
                       out_c0, out_c1, out_c2);
                fail_cnt++;
            end
            else
            begin
                want = rgb_expected_q.pop_front();
                check_field("out_c0", want.c0, out_c0);
                check_field("out_c1", want.c1, out_c1);
                check_field("out_c2", want.c2, out_c2);
            end
        end
    end

    task automatic push_load(input logic [INDEX_W-1:0] idx, input logic [15:0] v0,
                             input logic [15:0] v1, input logic [15:0] v2);
        clut_req_t rq;
        rq.func  = FUNC_LOAD;
        rq.index = idx;
        rq.c0    = v0;
        rq.c1    = v1;
        rq.c2    = v2;
        rq.r     = 16'($urandom);
        rq.g     = 16'($urandom);
        rq.b     = 16'($urandom);
        req_q.push_back(rq);
    endtask

    task automatic push_eval(input logic [15:0] r, input logic [15:0] g,
                             input logic [15:0] b);
        clut_req_t rq;
        rq.func  = FUNC_EVAL;
        rq.index = INDEX_W'($urandom);
        rq.c0    = 16'($urandom);
        rq.c1    = 16'($urandom);
        rq.c2    = 16'($urandom);
        rq.r     = r;
        rq.g     = g;
        rq.b     = b;
        req_q.push_back(rq);
    endtask

    // Channel value for a load, leaning on the two extremes now and then.
    function automatic logic [15:0] pick_level();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom);
    endfunction

    // Loads every entry around two cells per axis for grid gp: cell lo and
    // the last cell. Samples are kept inside these cells, so the cube only
    // needs these lattice points filled.
    task automatic preload_cells(input int unsigned gp, input int unsigned lo);
        int unsigned pts [$];
        pts.push_back(lo);
        pts.push_back(lo + 1);
        if (gp - 2 > lo + 1)
            pts.push_back(gp - 2);
        if (gp - 1 > lo + 1)
            pts.push_back(gp - 1);
        for (int ib = 0; ib < pts.size(); ib++)
            for (int ig = 0; ig < pts.size(); ig++)
                for (int ir = 0; ir < pts.size(); ir++)
                    push_load(INDEX_W'(pts[ib] * gp * gp + pts[ig] * gp + pts[ir]),
                              pick_level(), pick_level(), pick_level());
    endtask

    // Sample coordinate for grid gp inside cell lo or the last cell: codes
    // just on the lower lattice plane, the top of the cell (full scale in
    // the last cell), one below it, and plain random codes in the cell.
    function automatic logic [15:0] pick_code(input int unsigned gp,
                                              input int unsigned lo);
        int unsigned c;
        int unsigned lo_code;
        int unsigned hi_code;
        c       = $urandom_range(0, 1) ? lo : gp - 2;
        lo_code = (c * 65535 + gp - 2) / (gp - 1);
        if (c == gp - 2)
            hi_code = 65535;
        else
            hi_code = ((c + 1) * 65535 - 1) / (gp - 1);
        case ($urandom_range(0, 9))
            0: return 16'(lo_code);
            1: return 16'(hi_code);
            2: return 16'(hi_code - 1);
            default: return 16'($urandom_range(lo_code, hi_code));
        endcase
    endfunction

    // Returns once nothing is queued, offered or outstanding, plus enough
    // cycles for a trailing load to leave the pipeline.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (req_q.size() != 0 || in_valid || rgb_expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_grid(input logic [GRID_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        grid_shadow = val;
        phase_cnt++;
    endtask

    // One phase of random traffic at a new grid setting. Most requests are
    // evaluates; loads mostly hit the cube in use, some the rest of the
    // memory, and a few land past its end where they must be dropped.
    task automatic run_phase(input logic [GRID_W-1:0] val, input int n_req,
                             input bit pressure);
        int unsigned gp;
        int unsigned lo;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        int unsigned pick;

        wait_drained();
        write_grid(val);
        gp = val;
        if (gp < 2)
            gp = 2;
        if (gp > GRID_MAX)
            gp = GRID_MAX;
        lo = $urandom_range(0, gp - 2);
        preload_cells(gp, lo);

        if (pressure)
        begin
            sender_gaps   = 1'b0;
            long_hold_req = 1'b1;
        end

        for (int i = 0; i < n_req; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    push_load(INDEX_W'($urandom_range(0, gp * gp * gp - 1)),
                              pick_level(), pick_level(), pick_level());
                else if (pick < 17)
                    push_load(INDEX_W'($urandom_range(0, CUBE_N - 1)),
                              pick_level(), pick_level(), pick_level());
                else
                    push_load(INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1)),
                              pick_level(), pick_level(), pick_level());
            end
            else
            begin
                r = pick_code(gp, lo);
                g = pick_code(gp, lo);
                b = pick_code(gp, lo);
                // Equal fractions exercise the tie order between tetrahedra.
                case ($urandom_range(0, 7))
                    0: g = r;
                    1: b = g;
                    2: b = r;
                    3:
                    begin
                        g = r;
                        b = r;
                    end
                    default: ;
                endcase
                push_eval(r, g, b);
            end
        end

        if (pressure)
        begin
            wait_drained();
            sender_gaps = 1'b1;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The cube comes up with unknown contents, so the entries around the
        // first and the last cell are loaded before the first evaluate; the
        // grid is still at its reset size.
        preload_cells(32'(GRID_RESET), 0);
        wait_drained();

        // Directed part at the reset grid: origin, axis and far corners of the
        // unit cube, one sample in each tetrahedron of the first cell, tied
        // fractions, extreme entries, and loads past the end of the memory.
        push_eval(16'h0000, 16'h0000, 16'h0000);
        push_eval(16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_eval(16'hFFFF, 16'h0000, 16'h0000);
        push_eval(16'h0000, 16'hFFFF, 16'h0000);
        push_eval(16'h0000, 16'h0000, 16'hFFFF);
        push_eval(16'd2500, 16'd1875, 16'd1250);
        push_eval(16'd2500, 16'd1250, 16'd1875);
        push_eval(16'd1875, 16'd1250, 16'd2500);
        push_eval(16'd1875, 16'd2500, 16'd1250);
        push_eval(16'd1250, 16'd2500, 16'd1875);
        push_eval(16'd1250, 16'd1875, 16'd2500);
        push_eval(16'd1875, 16'd1875, 16'd1875);
        push_eval(16'd1875, 16'd1875, 16'd625);
        push_eval(16'd625, 16'd1875, 16'd1875);
        push_load(INDEX_W'(0), 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_load(INDEX_W'(CUBE_N - 1), 16'h0000, 16'h0000, 16'h0000);
        push_eval(16'h0000, 16'h0000, 16'h0000);
        push_eval(16'hFFFF, 16'hFFFF, 16'hFFFF);
        // Loads at and past the end of the memory must leave every entry
        // alone, including the corners read right after them.
        push_load({INDEX_W{1'b1}}, 16'h1234, 16'hABCD, 16'h5A5A);
        push_load(INDEX_W'(CUBE_N), 16'hFFFF, 16'h0000, 16'hFFFF);
        push_eval(16'hFFFF, 16'h0000, 16'hFFFF);

        // Random phases over a spread of grid settings, including the
        // values below two and above the maximum that the block clamps.
        run_phase(5'd2,  60, 1'b0);
        run_phase(5'd0,  60, 1'b0);
        run_phase(5'd1,  50, 1'b0);
        run_phase(5'd3,  60, 1'b0);
        run_phase(5'd31, 60, 1'b0);
        run_phase(5'd17, 120, 1'b1);
        run_phase(5'd5,  60, 1'b0);
        run_phase(5'd18, 50, 1'b0);
        run_phase(5'd9,  60, 1'b0);
        run_phase(5'd4,  50, 1'b0);
        run_phase(GRID_W'($urandom_range(2, GRID_MAX)), 60, 1'b0);
        wait_drained();

        $display("Covered %0d loads and %0d evaluates (%0d results checked) over %0d grid settings,",
                 load_cnt, eval_cnt, result_cnt, phase_cnt);
        $display("with bursty input, varied output stalls and %0d cycles of input backpressure.",
                 backpressure);
        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
sv/tclut_pkg.sv
sv/tclut_ram.sv
sv/tclut_locate.sv
sv/tclut_blend.sv
sv/tetrahedral_clut_interpolation.sv
sv/tclut_checker.sv
bench/tb_tetrahedral_clut_interpolation.sv
